/* hdl/rme_pkg.sv */
// shared constants and types for the modular exponentiation block
// no dependencies; used by the channel interfaces and the top level
package rme_pkg;

    localparam int WORD_WIDTH = 32;   // default arithmetic width
    localparam int FIELD_W    = 32;   // width of message and residue on the channels
    localparam int CFG_DATA_W = 32;   // widest configuration register
    localparam int CFG_IDX_W  = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 1'b1;

    localparam logic [CFG_DATA_W-1:0] MODULUS_RESET  = 32'd253;
    localparam logic [CFG_DATA_W-1:0] EXPONENT_RESET = 32'd17;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REDUCE,
        S_EXP,
        S_WAIT_OUT
    } t_state;

endpackage

/* hdl/rme_msg_if.sv */
// input channel carrying one message per item
// depends on rme_pkg for the field width
interface rme_msg_if;
    logic                         valid;
    logic                         ready;
    logic [rme_pkg::FIELD_W-1:0]  message;

    modport source (output valid, output message, input ready);
    modport sink   (input valid, input message, output ready);
endinterface

/* hdl/rme_res_if.sv */
// output channel carrying one residue per item
// depends on rme_pkg for the field width
interface rme_res_if;
    logic                         valid;
    logic                         ready;
    logic [rme_pkg::FIELD_W-1:0]  residue;

    modport source (output valid, output residue, input ready);
    modport sink   (input valid, input residue, output ready);
endinterface

/* hdl/rsa_modular_exponentiation_top.sv */
// modular exponentiation, right-to-left square-and-multiply, bit-serial
// depends on rme_pkg, rme_msg_if and rme_res_if
//
//  port     | dir | handshake     | payload
//  ---------+-----+---------------+-------------------------------
//  i_msg    | in  | valid / ready | message [31:0]
//  o_res    | out | valid / ready | residue [31:0]
//  i_cfg_*  | in  | we only       | idx 0 modulus, idx 1 exponent
//
// one item at a time: a reduce pass brings the message below the modulus, then one
// square-and-multiply pass per exponent bit up to the highest set one, each pass
// over WORD_WIDTH bits. an exponent of zero skips both and returns 1 via hand-over.
// the multiply and square each run one bit a cycle through a shift-add reducer.
// reset is synchronous; registers return to modulus 253, exponent 17.
// a finished result waits in the output register while the next item is taken;
// the engine stalls only when a second result is ready before the first is taken.
module rsa_modular_exponentiation_top #(
    parameter int WORD_WIDTH = rme_pkg::WORD_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rme_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rme_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    rme_msg_if.sink                          i_msg,
    rme_res_if.source                        o_res
);

    localparam int W     = WORD_WIDTH;
    localparam int CNT_W = $clog2(W);
    localparam int FW    = rme_pkg::FIELD_W;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(W - 1);

    rme_pkg::t_state r_state, n_state;

    logic [W-1:0]     r_mod, n_mod;
    logic [W-1:0]     r_exp, n_exp;
    logic [W-1:0]     r_e, n_e;          // exponent bits still to scan
    logic [W-1:0]     r_base, n_base;
    logic [W-1:0]     r_acc, n_acc;
    logic [W-1:0]     r_sa, n_sa;        // scanned operand of the multiply
    logic [W-1:0]     r_sb, n_sb;        // scanned operand of the square
    logic [W-1:0]     r_pa, n_pa;        // partial product of the multiply
    logic [W-1:0]     r_pb, n_pb;        // partial product of the square
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_res_valid, n_res_valid;
    logic [W-1:0]     r_res, n_res;

    logic [W:0]       w_m;
    logic [W+1:0]     w_m2;
    logic [W-1:0]     w_step_a, w_step_b;
    logic [W-1:0]     w_msg;
    logic             w_in_acc, w_out_free;

    // one bit of interleaved modular multiply: (2r + sel*addend) mod m, r and addend < m
    function automatic logic [W-1:0] mod_step(
        input logic [W-1:0] r,
        input logic         sel,
        input logic [W-1:0] addend,
        input logic [W:0]   m,
        input logic [W+1:0] m2
    );
        logic [W+1:0] t;
        logic [W+1:0] d;
        t = {1'b0, r, 1'b0} + (sel ? {2'b00, addend} : '0);
        if (t >= m2) begin
            d = t - m2;
        end else if (t >= {1'b0, m}) begin
            d = t - {1'b0, m};
        end else begin
            d = t;
        end
        return d[W-1:0];
    endfunction

    // a zero modulus stands for 2^W, so products simply wrap
    assign w_m  = (r_mod == '0) ? {1'b1, {W{1'b0}}} : {1'b0, r_mod};
    assign w_m2 = {w_m, 1'b0};

    assign w_msg      = i_msg.message[W-1:0];
    assign w_in_acc   = i_msg.valid && i_msg.ready;
    assign w_out_free = !r_res_valid || o_res.ready;

    // reduce pass adds 1 per message bit; exp pass adds the current base
    assign w_step_a = mod_step(r_pa, r_sa[W-1], r_base, w_m, w_m2);
    assign w_step_b = mod_step(r_pb, r_sb[W-1],
                               (r_state == rme_pkg::S_REDUCE) ? W'(1) : r_base, w_m, w_m2);

    assign i_msg.ready   = (r_state == rme_pkg::S_IDLE);
    assign o_res.valid   = r_res_valid;
    assign o_res.residue = FW'(r_res);

    always_comb begin
        n_state     = r_state;
        n_mod       = r_mod;
        n_exp       = r_exp;
        n_e         = r_e;
        n_base      = r_base;
        n_acc       = r_acc;
        n_sa        = r_sa;
        n_sb        = r_sb;
        n_pa        = r_pa;
        n_pb        = r_pb;
        n_cnt       = r_cnt;
        n_res       = r_res;
        n_res_valid = r_res_valid;

        if (r_res_valid && o_res.ready) begin
            n_res_valid = 1'b0;
        end

        if (i_cfg_we) begin
            case (i_cfg_idx)
                rme_pkg::CFG_MODULUS:  n_mod = i_cfg_data[W-1:0];
                rme_pkg::CFG_EXPONENT: n_exp = i_cfg_data[W-1:0];
                default: ;
            endcase
        end

        case (r_state)
            rme_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_acc = W'(1);
                    n_e   = r_exp;
                    n_sb  = w_msg;
                    n_pb  = '0;
                    n_cnt = '0;
                    if (r_exp == '0) begin
                        n_state = rme_pkg::S_WAIT_OUT;
                    end else begin
                        n_state = rme_pkg::S_REDUCE;
                    end
                end
            end
            rme_pkg::S_REDUCE: begin
                n_pb  = w_step_b;
                n_sb  = {r_sb[W-2:0], 1'b0};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == LAST) begin
                    n_base  = w_step_b;
                    n_sa    = r_acc;
                    n_sb    = w_step_b;
                    n_pa    = '0;
                    n_pb    = '0;
                    n_cnt   = '0;
                    n_state = rme_pkg::S_EXP;
                end
            end
            rme_pkg::S_EXP: begin
                n_pa  = w_step_a;
                n_pb  = w_step_b;
                n_sa  = {r_sa[W-2:0], 1'b0};
                n_sb  = {r_sb[W-2:0], 1'b0};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == LAST) begin
                    // commit multiply on a set bit, square always
                    if (r_e[0]) begin
                        n_acc = w_step_a;
                    end
                    n_base = w_step_b;
                    n_e    = r_e >> 1;
                    n_sa   = r_e[0] ? w_step_a : r_acc;
                    n_sb   = w_step_b;
                    n_pa   = '0;
                    n_pb   = '0;
                    n_cnt  = '0;
                    if ((r_e >> 1) == '0) begin
                        n_state = rme_pkg::S_WAIT_OUT;
                    end
                end
            end
            rme_pkg::S_WAIT_OUT: begin
                if (w_out_free) begin
                    n_res       = r_acc;
                    n_res_valid = 1'b1;
                    n_state     = rme_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rme_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rme_pkg::S_IDLE;
            r_res_valid <= 1'b0;
            r_mod       <= rme_pkg::MODULUS_RESET[W-1:0];
            r_exp       <= rme_pkg::EXPONENT_RESET[W-1:0];
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
            r_mod       <= n_mod;
            r_exp       <= n_exp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e    <= n_e;
        r_base <= n_base;
        r_acc  <= n_acc;
        r_sa   <= n_sa;
        r_sb   <= n_sb;
        r_pa   <= n_pa;
        r_pb   <= n_pb;
        r_cnt  <= n_cnt;
        r_res  <= n_res;
    end

`ifndef SYNTHESIS
    // partial products and the base stay reduced during the exponent pass
    a_partial_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == rme_pkg::S_EXP) && (r_mod != '0))
            |-> (r_pa < r_mod) && (r_pb < r_mod) && (r_base < r_mod))
        else $error("partial product not reduced");

    // the exponent pass never runs with no bits left
    a_exp_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rme_pkg::S_EXP) |-> (r_e != '0))
        else $error("exponent pass with empty exponent");

    // a finished residue is below the modulus unless the exponent is zero
    a_result_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == rme_pkg::S_WAIT_OUT) && (r_exp != '0) && (r_mod != '0))
            |-> (r_acc < r_mod))
        else $error("result not reduced");

    // a new result is only loaded from the hand-over state
    a_load_from_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_res_valid) |-> ($past(r_state) == rme_pkg::S_WAIT_OUT))
        else $error("result loaded outside hand-over");
`endif

endmodule
